// ----- rtl/qks_pkg.sv -----
// Shared constants, types and state codes of the k-th smallest selector.
`timescale 1ns / 1ps
package qks_pkg;
  localparam int DEPTH      = 1024;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int RANK_W     = 11;
  localparam int CMP_W      = (RANK_W > CNT_W) ? RANK_W : CNT_W;
  localparam int LFSR_W     = 16;
  localparam int BIT_W      = $clog2(LFSR_W);
  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

  typedef logic signed [DATA_WIDTH-1:0] data_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MOD_INIT,
    ST_MOD_STEP,
    ST_SW0,
    ST_SW1,
    ST_SW2,
    ST_SW3,
    ST_CHK,
    ST_RI_REQ,
    ST_RI_CHK,
    ST_RJ_REQ,
    ST_RJ_CHK,
    ST_SWJ,
    ST_FIN0,
    ST_FIN1,
    ST_FIN2,
    ST_DONE
  } state_t;
endpackage

// ----- rtl/qks_in_if.sv -----
// Input channel: one list element per transaction.
`timescale 1ns / 1ps
interface qks_in_if;
  logic                          valid;
  logic                          ready;
  logic [qks_pkg::DATA_WIDTH-1:0] value;
  logic                          last;
  logic [qks_pkg::RANK_W-1:0]     rank;
  modport source (output valid, value, last, rank, input ready);
  modport sink   (input valid, value, last, rank, output ready);
endinterface

// ----- rtl/qks_out_if.sv -----
// Output channel: one selection result per transaction.
`timescale 1ns / 1ps
interface qks_out_if;
  logic                          valid;
  logic                          ready;
  logic [qks_pkg::DATA_WIDTH-1:0] kth_value;
  logic                          error;
  modport source (output valid, kth_value, error, input ready);
  modport sink   (input valid, kth_value, error, output ready);
endinterface

// ----- rtl/quickselect_kth_smallest.sv -----
// K-th smallest selector: loads a list into a memory, then runs quickselect in place.
`timescale 1ns / 1ps
// Elements are loaded one per cycle while the selector is idle into a single-port-write,
// registered-read memory; the item flagged last carries the rank k. Each quickselect round
// advances a 16-bit LFSR, reduces it modulo the range length with a bit-serial remainder
// unit, parks the pivot at the left end and partitions with two scanning pointers, swapping
// pairs and then placing the pivot; all of it goes through the one memory read port. The
// expected work is linear in the list length, and no item is taken during the selection.
// An error (rank zero, rank above the count, or a load past capacity) skips the selection
// and is reported with a zero value. A finished result sits in an output register, so the
// next list can load while it waits.
module quickselect_kth_smallest (
  input  logic      clk,
  input  logic      rst,
  qks_in_if.sink    items,
  qks_out_if.source results
);
  import qks_pkg::*;

  data_t mem [DEPTH];
  data_t rdata;
  logic              we;
  logic [ADDR_W-1:0] waddr, raddr;
  data_t             wdata;

  state_t state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  logic              overflow, overflow_next;
  logic [LFSR_W-1:0] lfsr, lfsr_next;
  logic [ADDR_W-1:0] lo, lo_next, hi, hi_next, i, i_next, j, j_next, off, off_next;
  logic [CNT_W-1:0]  k, k_next, rem, rem_next;
  logic [BIT_W-1:0]  bitidx, bitidx_next;
  data_t             pv, pv_next, tmp, tmp_next;
  logic              res_err, res_err_next;
  logic              out_valid, out_valid_next;
  data_t             out_value, out_value_next;
  logic              out_error, out_error_next;

  logic [CNT_W-1:0]  len, part_len, cnt_new;
  logic [CNT_W:0]    sh;
  logic              full, err_now;
  logic [ADDR_W-1:0] poff;

  assign items.ready       = (state == ST_IDLE);
  assign results.valid     = out_valid;
  assign results.kth_value = out_value;
  assign results.error     = out_error;

  assign len      = CNT_W'(hi - lo) + CNT_W'(1);
  assign part_len = CNT_W'(j - lo) + CNT_W'(1);
  assign poff = lo + off;
  assign full = (count == CNT_W'(DEPTH));
  assign cnt_new = full ? count : count + CNT_W'(1);
  assign err_now = overflow || full || (items.rank == '0)
                   || (CMP_W'(items.rank) > CMP_W'(cnt_new));
  assign sh = {rem, lfsr[bitidx]};

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      overflow  <= 1'b0;
      lfsr      <= LFSR_SEED;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      overflow  <= overflow_next;
      lfsr      <= lfsr_next;
      out_valid <= out_valid_next;
    end
    lo <= lo_next; hi <= hi_next; i <= i_next; j <= j_next; off <= off_next;
    k <= k_next; rem <= rem_next; bitidx <= bitidx_next;
    pv <= pv_next; tmp <= tmp_next; res_err <= res_err_next;
    out_value <= out_value_next; out_error <= out_error_next;
  end

  always_comb begin
    state_next = state;
    count_next = count; overflow_next = overflow; lfsr_next = lfsr;
    lo_next = lo; hi_next = hi; i_next = i; j_next = j; off_next = off;
    k_next = k; rem_next = rem; bitidx_next = bitidx;
    pv_next = pv; tmp_next = tmp; res_err_next = res_err;
    out_valid_next = out_valid; out_value_next = out_value; out_error_next = out_error;
    we = 1'b0; waddr = '0; wdata = pv; raddr = i;

    if (out_valid && results.ready) begin
      out_valid_next = 1'b0;
    end

    unique case (state)
      ST_IDLE: begin
        if (items.valid) begin
          if (!full) begin
            we    = 1'b1;
            waddr = count[ADDR_W-1:0];
            wdata = data_t'(items.value);
          end
          count_next    = cnt_new;
          overflow_next = overflow || full;
          if (items.last) begin
            count_next    = '0;
            overflow_next = 1'b0;
            lo_next       = '0;
            hi_next       = ADDR_W'(cnt_new - CNT_W'(1));
            k_next        = CNT_W'(items.rank);
            res_err_next  = err_now;
            pv_next       = '0;
            state_next    = err_now ? ST_DONE : ST_MOD_INIT;
          end
        end
      end
      ST_MOD_INIT: begin
        lfsr_next   = {lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5], lfsr[LFSR_W-1:1]};
        rem_next    = '0;
        bitidx_next = BIT_W'(LFSR_W - 1);
        state_next  = ST_MOD_STEP;
      end
      ST_MOD_STEP: begin
        // One remainder bit per cycle, most significant LFSR bit first.
        if (sh >= {1'b0, len}) begin
          rem_next = CNT_W'(sh - {1'b0, len});
        end else begin
          rem_next = CNT_W'(sh);
        end
        bitidx_next = bitidx - BIT_W'(1);
        if (bitidx == '0) begin
          state_next = ST_SW0;
        end
      end
      ST_SW0: begin
        off_next   = ADDR_W'(rem);
        raddr      = lo + ADDR_W'(rem);
        state_next = ST_SW1;
      end
      ST_SW1: begin
        pv_next    = rdata;
        raddr      = lo;
        state_next = ST_SW2;
      end
      ST_SW2: begin
        tmp_next   = rdata;
        we         = 1'b1;
        waddr      = lo;
        wdata      = pv;
        state_next = ST_SW3;
      end
      ST_SW3: begin
        we         = 1'b1;
        waddr      = poff;
        wdata      = tmp;
        i_next     = lo;
        j_next     = hi;
        state_next = ST_CHK;
      end
      ST_CHK: begin
        state_next = (i < j) ? ST_RI_REQ : ST_FIN0;
      end
      ST_RI_REQ: begin
        raddr      = i;
        state_next = ST_RI_CHK;
      end
      ST_RI_CHK: begin
        if (rdata <= pv && i != hi) begin
          i_next = i + ADDR_W'(1);
          raddr  = i + ADDR_W'(1);
        end else begin
          tmp_next   = rdata;
          state_next = ST_RJ_REQ;
        end
      end
      ST_RJ_REQ: begin
        raddr      = j;
        state_next = ST_RJ_CHK;
      end
      ST_RJ_CHK: begin
        if (!(rdata <= pv)) begin
          j_next = j - ADDR_W'(1);
          raddr  = j - ADDR_W'(1);
        end else if (i < j) begin
          we         = 1'b1;
          waddr      = i;
          wdata      = rdata;
          state_next = ST_SWJ;
        end else begin
          state_next = ST_FIN0;
        end
      end
      ST_SWJ: begin
        // The reread of entry i after this write sees the swapped value.
        we         = 1'b1;
        waddr      = j;
        wdata      = tmp;
        state_next = ST_RI_REQ;
      end
      ST_FIN0: begin
        raddr      = j;
        state_next = ST_FIN1;
      end
      ST_FIN1: begin
        we         = 1'b1;
        waddr      = lo;
        wdata      = rdata;
        state_next = ST_FIN2;
      end
      ST_FIN2: begin
        we    = 1'b1;
        waddr = j;
        wdata = pv;
        if (part_len == k) begin
          state_next = ST_DONE;
        end else if (part_len > k) begin
          hi_next    = j - ADDR_W'(1);
          state_next = ST_MOD_INIT;
        end else begin
          k_next     = k - part_len;
          lo_next    = j + ADDR_W'(1);
          state_next = ST_MOD_INIT;
        end
      end
      ST_DONE: begin
        if (!out_valid || results.ready) begin
          out_valid_next = 1'b1;
          out_value_next = res_err ? data_t'(0) : pv;
          out_error_next = res_err;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  a_lfsr_nonzero: assert property (@(posedge clk) disable iff (rst) lfsr != '0)
    else $error("pivot LFSR reached the all-zero lockup state");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("element count exceeds capacity");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_error |-> out_value == '0)
    else $error("error result carries a nonzero value");
  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RI_CHK || state == ST_RJ_CHK) |-> (i <= hi && j >= lo))
    else $error("partition pointer left the active range");
endmodule
